FILE: rtl/core/qamllr_pkg.sv
// Shared types, register codes and the PAM level tables of the QAM LLR demapper.
// No dependencies; used by qamllr_rail and qam_maxlog_llr_demapper_top.
`timescale 1ns / 1ps
`default_nettype none
package qamllr_pkg;

   // Register indexes of the configuration port.
   localparam logic CSR_BITS_PER_RAIL = 1'b0;
   localparam logic CSR_LLR_SCALE     = 1'b1;

   localparam int BPR_W   = 3;
   localparam int SCALE_W = 24;
   localparam int LEVEL_W = 14;
   localparam int NUM_SLOTS = 8;

   typedef logic signed [LEVEL_W-1:0] level_type;

   // Control shared by the rail lanes: pipeline advance and live configuration.
   typedef struct packed {
      logic               adv;
      logic [BPR_W-1:0]   bpr;
      logic [SCALE_W-1:0] scale;
   } ctl_type;

   // Normalised Gray PAM level j for a rail of bpr bits, in Q1.12.
   function automatic level_type level_q(input logic [BPR_W-1:0] bpr, input logic [3:0] j);
      level_type lv;
      lv = '0;
      case (bpr)
         3'd2: begin
            case (j)
               4'd0: lv = 14'sd1295;
               4'd1: lv = 14'sd3886;
               4'd2: lv = -14'sd1295;
               4'd3: lv = -14'sd3886;
               default: lv = '0;
            endcase
         end
         3'd3: begin
            case (j)
               4'd0: lv = 14'sd1896;
               4'd1: lv = 14'sd632;
               4'd2: lv = 14'sd3160;
               4'd3: lv = 14'sd4424;
               4'd4: lv = -14'sd1896;
               4'd5: lv = -14'sd632;
               4'd6: lv = -14'sd3160;
               4'd7: lv = -14'sd4424;
               default: lv = '0;
            endcase
         end
         3'd4: begin
            case (j)
               4'd0: lv = 14'sd1571;
               4'd1: lv = 14'sd2199;
               4'd2: lv = 14'sd942;
               4'd3: lv = 14'sd314;
               4'd4: lv = 14'sd3456;
               4'd5: lv = 14'sd2827;
               4'd6: lv = 14'sd4084;
               4'd7: lv = 14'sd4712;
               4'd8: lv = -14'sd1571;
               4'd9: lv = -14'sd2199;
               4'd10: lv = -14'sd942;
               4'd11: lv = -14'sd314;
               4'd12: lv = -14'sd3456;
               4'd13: lv = -14'sd2827;
               4'd14: lv = -14'sd4084;
               4'd15: lv = -14'sd4712;
               default: lv = '0;
            endcase
         end
         default: begin
            case (j)
               4'd0: lv = 14'sd2896;
               4'd1: lv = -14'sd2896;
               default: lv = '0;
            endcase
         end
      endcase
      return lv;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/qamllr_rail.sv
// One rail lane: squared distances to all levels, per-bit minima and scaled LLRs.
// Five register stages, all advancing on ctl.adv. Depends on qamllr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qamllr_rail #(
   parameter int SAMPLE_WIDTH      = 16,
   parameter int LLR_WIDTH         = 16,
   parameter int MAX_BITS_PER_RAIL = 4
) (
   input  wire logic                          clock,
   input  wire qamllr_pkg::ctl_type           ctl,
   input  wire logic signed [SAMPLE_WIDTH-1:0] rx,
   output logic signed [LLR_WIDTH-1:0]        llr [MAX_BITS_PER_RAIL]
);
   import qamllr_pkg::*;

   localparam int MAXB = MAX_BITS_PER_RAIL;
   localparam int NLV  = 1 << MAXB;
   localparam int DW   = ((SAMPLE_WIDTH > LEVEL_W) ? SAMPLE_WIDTH : LEVEL_W) + 1;
   localparam int MW   = 2 * DW;
   localparam int LO   = (MW + 1) / 2;
   localparam int HI   = MW - LO;
   localparam int PW   = MW + SCALE_W + 1;
   localparam int QW   = PW - 32;
   localparam int CW   = ((QW > LLR_WIDTH) ? QW : LLR_WIDTH) + 1;
   localparam logic [CW-1:0] LIM_POS = CW'((64'd1 << (LLR_WIDTH - 1)) - 64'd1);
   localparam logic [CW-1:0] LIM_NEG = CW'(64'd1 << (LLR_WIDTH - 1));

   logic [MW-1:0] sq_in [NLV];
   logic [MW-1:0] sq_ff [NLV];
   logic [MW-1:0] m0_in [MAXB];
   logic [MW-1:0] m1_in [MAXB];
   logic [MW-1:0] m0_ff [MAXB];
   logic [MW-1:0] m1_ff [MAXB];
   logic          neg3_ff [MAXB];
   logic [MW-1:0] mag3_ff [MAXB];
   logic          neg4_ff [MAXB];
   logic [LO+SCALE_W-1:0] plo4_ff [MAXB];
   logic [HI+SCALE_W-1:0] phi4_ff [MAXB];
   logic signed [LLR_WIDTH-1:0] llr_in [MAXB];
   logic signed [LLR_WIDTH-1:0] llr_ff [MAXB];

   // Stage 1: squared distance to every level of the mode; unused levels read as maximum.
   always_comb begin
      logic signed [DW-1:0] d;
      logic [DW-1:0] ad;
      for (int j = 0; j < NLV; j++) begin
         d  = DW'(rx) - DW'(level_q(ctl.bpr, 4'(j)));
         ad = d[DW-1] ? DW'(-d) : DW'(d);
         if (j < (1 << ctl.bpr)) begin
            sq_in[j] = MW'(ad) * MW'(ad);
         end else begin
            sq_in[j] = '1;
         end
      end
   end

   // Stage 2: minimum over each bit's two level classes, by a tree.
   always_comb begin
      logic [MW-1:0] t0 [NLV];
      logic [MW-1:0] t1 [NLV];
      logic cls;
      int sh;
      for (int k = 0; k < MAXB; k++) begin
         sh = int'(ctl.bpr) - 1 - k;
         for (int j = 0; j < NLV; j++) begin
            cls = (sh >= 0) ? ((j >> sh) & 1) != 0 : 1'b0;
            t0[j] = cls ? '1 : sq_ff[j];
            t1[j] = cls ? sq_ff[j] : '1;
         end
         for (int s = 0; s < MAXB; s++) begin
            for (int i = 0; i < (NLV >> (s + 1)); i++) begin
               t0[i] = (t0[2*i+1] < t0[2*i]) ? t0[2*i+1] : t0[2*i];
               t1[i] = (t1[2*i+1] < t1[2*i]) ? t1[2*i+1] : t1[2*i];
            end
         end
         m0_in[k] = t0[0];
         m1_in[k] = t1[0];
      end
   end

   // Stage 5: recombine partial products, round half away from zero, saturate.
   always_comb begin
      logic [PW-1:0] prod;
      logic [CW-1:0] q;
      for (int k = 0; k < MAXB; k++) begin
         prod = PW'({phi4_ff[k], {LO{1'b0}}}) + PW'(plo4_ff[k]) + PW'(64'd1 << 31);
         q    = CW'(prod[PW-1:32]);
         if (neg4_ff[k]) begin
            llr_in[k] = (q > LIM_NEG) ? LLR_WIDTH'(-LIM_NEG) : LLR_WIDTH'(-q);
         end else begin
            llr_in[k] = (q > LIM_POS) ? LLR_WIDTH'(LIM_POS) : LLR_WIDTH'(q);
         end
      end
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         sq_ff <= sq_in;
         for (int k = 0; k < MAXB; k++) begin
            m0_ff[k]   <= m0_in[k];
            m1_ff[k]   <= m1_in[k];
            neg3_ff[k] <= m1_ff[k] < m0_ff[k];
            mag3_ff[k] <= (m1_ff[k] < m0_ff[k]) ? m0_ff[k] - m1_ff[k] : m1_ff[k] - m0_ff[k];
            neg4_ff[k] <= neg3_ff[k];
            plo4_ff[k] <= (LO+SCALE_W)'(mag3_ff[k][LO-1:0]) * (LO+SCALE_W)'(ctl.scale);
            phi4_ff[k] <= (HI+SCALE_W)'(mag3_ff[k][MW-1:LO]) * (HI+SCALE_W)'(ctl.scale);
            llr_ff[k]  <= llr_in[k];
         end
      end
   end

   assign llr = llr_ff;

endmodule
`default_nettype wire

FILE: rtl/core/qam_maxlog_llr_demapper_top.sv
// Top level of the max-log LLR demapper: registers, two rail lanes and the merge stage.
// Depends on qamllr_pkg and qamllr_rail.
`timescale 1ns / 1ps
`default_nettype none
// Max-log soft demapper for square QPSK, 16QAM, 64QAM and 256QAM. One symbol is taken per
// clock and its result passes through five stages in each rail lane (distance
// squaring, class minima, difference, split scale product, rounding) and one merge register.
// Throughput is one item per cycle; the pipeline stalls as a whole while a result waits.
// LLRs of bits beyond the configured mode are zero; an invalid mode behaves as QPSK.
module qam_maxlog_llr_demapper_top #(
   parameter int SAMPLE_WIDTH      = 16,
   parameter int LLR_WIDTH         = 16,
   parameter int MAX_BITS_PER_RAIL = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic csr_index,
   input  wire logic [qamllr_pkg::SCALE_W-1:0] csr_wdata,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // rx_i, rx_q, zero padding
   input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,
   input  wire logic req_tlast,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // llr_0 .. llr_7, zero padding
   output logic [((qamllr_pkg::NUM_SLOTS*LLR_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast
);
   import qamllr_pkg::*;

   localparam int MAXB  = MAX_BITS_PER_RAIL;
   localparam int DEPTH = 5;
   localparam int OW    = ((NUM_SLOTS*LLR_WIDTH+7)/8)*8;

   logic [BPR_W-1:0]   bpr_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [BPR_W-1:0]   bpr_eff;
   logic [DEPTH-1:0]   vld_ff;
   logic [DEPTH-1:0]   last_ff;
   logic               rsp_valid_ff;
   logic               rsp_last_ff;
   logic [OW-1:0]      rsp_data_ff;
   logic [OW-1:0]      rsp_data_in;
   ctl_type            ctl;
   logic signed [LLR_WIDTH-1:0] llr_i [MAXB];
   logic signed [LLR_WIDTH-1:0] llr_q [MAXB];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bpr_ff   <= 3'd1;
         scale_ff <= 24'd8192;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BITS_PER_RAIL: bpr_ff   <= csr_wdata[BPR_W-1:0];
            CSR_LLR_SCALE:     scale_ff <= csr_wdata;
            default:           bpr_ff   <= bpr_ff;
         endcase
      end
   end

   // Out-of-range modes fall back to QPSK.
   assign bpr_eff = (bpr_ff < 3'd1 || bpr_ff > 3'd4 || int'(bpr_ff) > MAXB) ? 3'd1 : bpr_ff;

   // The whole pipeline moves unless a finished item is held at the output.
   assign ctl.adv   = !rsp_valid_ff || rsp_tready;
   assign ctl.bpr   = bpr_eff;
   assign ctl.scale = scale_ff;
   assign req_tready = ctl.adv;

   qamllr_rail #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH), .LLR_WIDTH(LLR_WIDTH), .MAX_BITS_PER_RAIL(MAX_BITS_PER_RAIL)
   ) u_rail_i (
      .clock(clock), .ctl(ctl), .rx(req_tdata[SAMPLE_WIDTH-1:0]), .llr(llr_i)
   );

   qamllr_rail #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH), .LLR_WIDTH(LLR_WIDTH), .MAX_BITS_PER_RAIL(MAX_BITS_PER_RAIL)
   ) u_rail_q (
      .clock(clock), .ctl(ctl), .rx(req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]), .llr(llr_q)
   );

   // Merge: interleave I and Q LLRs and clear the slots beyond the mode.
   always_comb begin
      rsp_data_in = '0;
      for (int k = 0; k < MAXB; k++) begin
         if (k < int'(bpr_eff)) begin
            rsp_data_in[2*k*LLR_WIDTH +: LLR_WIDTH]     = llr_i[k];
            rsp_data_in[(2*k+1)*LLR_WIDTH +: LLR_WIDTH] = llr_q[k];
         end
      end
   end

   // Valid and end-of-block shift lines alongside the lanes, then the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (ctl.adv) begin
         vld_ff       <= {vld_ff[DEPTH-2:0], req_tvalid};
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         last_ff     <= {last_ff[DEPTH-2:0], req_tlast};
         rsp_last_ff <= last_ff[DEPTH-1];
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: tb/sv/qam_maxlog_llr_demapper_top_tb.sv
// Self-checking bench for the max-log QAM LLR demapper top level.
// Predicts each symbol's LLRs from its own level tables; depends on qamllr_pkg and the RTL.
`timescale 1ns / 1ps
module qam_maxlog_llr_demapper_top_tb;
   import qamllr_pkg::*;

   localparam int SW = 16;
   localparam int LW = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic          eob;
      logic [31:0]   iq;
   } sym_type;

   typedef struct packed {
      logic          eob;
      logic [127:0]  llrs;
   } llr_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = CSR_BITS_PER_RAIL;
   logic [SCALE_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic rsp_tlast;

   qam_maxlog_llr_demapper_top u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #10 clock = ~clock;

   sym_type     pending_syms[$];
   llr_set_type expected_llrs[$];
   logic [BPR_W-1:0]   mode_bpr = 3'd1;
   logic [SCALE_W-1:0] mode_scale = 24'd8192;
   int  mismatches = 0;
   int  cycles = 0;
   bit  calm = 1'b0;
   bit  hold_rx = 1'b0;
   int  tx_gap = 0;
   int  rx_gap = 0;
   int  hold_count = 0;

   // Normalised Gray PAM level j of a bpr-bit rail, in Q1.12.
   function automatic int pam_level(int bpr, int j);
      int t2[4] = '{1295, 3886, -1295, -3886};
      int t3[8] = '{1896, 632, 3160, 4424, -1896, -632, -3160, -4424};
      int t4[16] = '{1571, 2199, 942, 314, 3456, 2827, 4084, 4712,
                     -1571, -2199, -942, -314, -3456, -2827, -4084, -4712};
      case (bpr)
         2: return t2[j];
         3: return t3[j];
         4: return t4[j];
         default: return (j == 0) ? 2896 : -2896;
      endcase
   endfunction

   // Max-log LLR of bit k for one rail sample, rounded and saturated.
   function automatic logic [LW-1:0] rail_bit_llr(int r, int bpr, int k, longint unsigned sc);
      longint unsigned m0, m1, mag, prod, q, d2;
      longint d;
      bit neg;
      m0 = '1;
      m1 = '1;
      for (int j = 0; j < (1 << bpr); j++) begin
         d = r - pam_level(bpr, j);
         d2 = d * d;
         if ((j >> (bpr - 1 - k)) & 1) begin
            if (d2 < m1) m1 = d2;
         end else begin
            if (d2 < m0) m0 = d2;
         end
      end
      neg = m1 < m0;
      mag = neg ? m0 - m1 : m1 - m0;
      prod = mag * sc;
      q = (prod + (64'd1 << 31)) >> 32;
      if (neg) begin
         if (q > 32768) q = 32768;
         return LW'(-longint'(q));
      end
      if (q > 32767) q = 32767;
      return LW'(q);
   endfunction

   function automatic llr_set_type demap_symbol(sym_type s);
      llr_set_type e;
      int bpr;
      int ri, rq;
      bpr = mode_bpr;
      if (bpr < 1 || bpr > 4) bpr = 1;
      ri = $signed(s.iq[15:0]);
      rq = $signed(s.iq[31:16]);
      e.llrs = '0;
      e.eob = s.eob;
      for (int k = 0; k < bpr; k++) begin
         e.llrs[(2*k)*LW +: LW] = rail_bit_llr(ri, bpr, k, mode_scale);
         e.llrs[(2*k+1)*LW +: LW] = rail_bit_llr(rq, bpr, k, mode_scale);
      end
      return e;
   endfunction

   task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      mismatches++;
   endtask

   // Driver: offers queued symbols, with random gaps while not in the calm part.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_llrs.push_back(demap_symbol(pending_syms.pop_front()));
         end
         if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            req_tvalid <= 1'b0;
         end else if ((!req_tvalid || req_tready) && !calm && $urandom_range(0, 9) == 0) begin
            tx_gap <= $urandom_range(0, 16);
            req_tvalid <= 1'b0;
         end else if (pending_syms.size() > 0) begin
            sym_type nx;
            nx = pending_syms[0];
            req_tvalid <= 1'b1;
            req_tdata <= nx.iq;
            req_tlast <= nx.eob;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: stalls at random and checks every accepted item.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_llrs.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata, '0);
            end else begin
               llr_set_type w;
               w = expected_llrs.pop_front();
               for (int s = 0; s < NUM_SLOTS; s++)
                  if (rsp_tdata[s*LW +: LW] !== w.llrs[s*LW +: LW])
                     report_mismatch($sformatf("llr_%0d", s),
                                     rsp_tdata[s*LW +: LW], w.llrs[s*LW +: LW]);
               if (rsp_tlast !== w.eob)
                  report_mismatch("tlast", rsp_tlast, w.eob);
            end
         end
         if (hold_rx) begin
            hold_count <= hold_count + 1;
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_syms.size() != 0 || req_tvalid || expected_llrs.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [SCALE_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BITS_PER_RAIL) mode_bpr = val[BPR_W-1:0];
      else mode_scale = val;
   endtask

   function automatic sym_type rand_sym();
      sym_type s;
      s.iq = $urandom;
      // Mostly samples near the constellation, sometimes anywhere.
      if ($urandom_range(0, 3) != 0) begin
         s.iq[15:0] = 16'($signed($urandom_range(0, 12000)) - 6000);
         s.iq[31:16] = 16'($signed($urandom_range(0, 12000)) - 6000);
      end
      s.eob = ($urandom_range(0, 7) == 0);
      return s;
   endfunction

   initial begin
      logic [15:0] edges[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0b50, 16'hf4b0};
      logic [SCALE_W-1:0] scales[6] = '{24'd8192, 24'hffffff, 24'd0, 24'd1, 24'd4096, 24'd40000};
      sym_type s;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // Directed: field extremes in the reset mode, then each mode and invalid ones.
      for (int a = 0; a < 6; a++) begin
         s.iq = {edges[5-a], edges[a]};
         s.eob = a[0];
         pending_syms.push_back(s);
      end
      wait_drained();
      for (int m = 0; m < 8; m++) begin
         write_reg(CSR_BITS_PER_RAIL, SCALE_W'(m));
         write_reg(CSR_LLR_SCALE, scales[m % 6]);
         for (int a = 0; a < 2; a++) begin
            s.iq = {edges[a + 2], edges[a]};
            s.eob = 1'b1;
            pending_syms.push_back(s);
         end
         wait_drained();
      end
      // Random phases across modes and scales.
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(CSR_BITS_PER_RAIL, SCALE_W'((ph % 5 == 4) ? $urandom_range(5, 7)
                                                             : (ph % 4) + 1));
         write_reg(CSR_LLR_SCALE, (ph == 3) ? 24'hffffff : (ph == 6) ? 24'd0
                                 : SCALE_W'($urandom_range(1000, 60000)));
         if (ph == 8) calm = 1'b1;
         if (ph == 5) hold_rx = 1'b1;
         for (int n = 0; n < 120; n++) pending_syms.push_back(rand_sym());
         if (ph == 5) begin
            while (hold_count < 300) @(posedge clock);
            hold_rx = 1'b0;
         end
         wait_drained();
      end
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
